@@ hdl/hlt_pkg.sv @@
// Shared types, codes and limits of the header line tokenizer.
// Used by every module of the block but hlt_ram; depends on nothing.
package hlt_pkg;

    localparam int LINE_MAX_DEF  = 64;
    localparam int NAME_MAX_DEF  = 32;
    localparam int VALUE_MAX_DEF = 64;
    localparam int TABLE_MAX_DEF = 16;

    localparam int POS_W = 6;
    localparam int CNT_W = 5;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_SKIP   = 3'd1;
    localparam logic [2:0] ST_END    = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_BADNM  = 3'd4;
    localparam logic [2:0] ST_VLONG  = 3'd5;
    localparam logic [2:0] ST_LLONG  = 3'd6;

    localparam logic [1:0] PH_COLLECT = 2'd0;
    localparam logic [1:0] PH_ENDED   = 2'd1;
    localparam logic [1:0] PH_FAILED  = 2'd2;

    typedef struct packed {
        logic             emit;
        logic [2:0]       status;
        logic [3:0]       idx;
        logic [POS_W-1:0] nb;
        logic [POS_W-1:0] ne;
        logic [POS_W-1:0] vb;
        logic [POS_W-1:0] ve;
        logic             vempty;
    } t_job;

    typedef struct packed {
        logic             nonblank;
        logic             colon;
        logic             seen_n;
        logic [POS_W-1:0] nb;
        logic [POS_W-1:0] ne;
        logic             seen_v;
        logic [POS_W-1:0] vb;
        logic [POS_W-1:0] ve;
    } t_line;

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SP || b == CH_TAB || b == CH_FF || b == CH_VT || b == CH_CR;
    endfunction

endpackage

@@ hdl/hlt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module hlt_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/hlt_front.sv @@
// Front part: accepts bytes, writes the line store and tracks trim bounds.
// Queues one job per finished line or error. Depends on hlt_pkg.
module hlt_front #(
    parameter int LINE_MAX  = hlt_pkg::LINE_MAX_DEF,
    parameter int NAME_MAX  = hlt_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = hlt_pkg::VALUE_MAX_DEF,
    parameter int TABLE_MAX = hlt_pkg::TABLE_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_byte,
    input  logic                      i_start,
    input  logic                      i_char_busy,
    input  logic                      i_q_full,
    output logic                      o_push,
    output hlt_pkg::t_job             o_job,
    output logic                      o_we,
    output logic [hlt_pkg::POS_W-1:0] o_waddr,
    output logic [7:0]                o_wdata
);
    import hlt_pkg::*;

    logic [POS_W-1:0] r_len, n_len;
    logic             r_held, n_held;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_phase, n_phase;
    logic             r_pend, n_pend;
    logic [7:0]       r_pbyte, n_pbyte;
    t_line            r_line, n_line;

    logic             st_do;
    logic [7:0]       st_x;
    logic             acc;
    logic [POS_W-1:0] nlen, vlen;

    assign o_ready = !r_pend && !i_q_full && !i_char_busy;
    assign acc     = i_valid && o_ready;
    assign nlen    = r_line.seen_n ? r_line.ne - r_line.nb : '0;
    assign vlen    = r_line.seen_v ? r_line.ve - r_line.vb : '0;

    always_comb begin
        n_len   = r_len;
        n_held  = r_held;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_pend  = r_pend;
        n_pbyte = r_pbyte;
        n_line  = r_line;
        o_push  = 1'b0;
        o_job   = '0;
        o_we    = 1'b0;
        o_waddr = r_len;
        o_wdata = 8'h00;
        st_do   = 1'b0;
        st_x    = 8'h00;
        if (r_pend) begin
            st_do  = 1'b1;
            st_x   = r_pbyte;
            n_pend = 1'b0;
        end else if (acc) begin
            if (i_start) begin
                n_len   = '0;
                n_held  = 1'b0;
                n_cnt   = '0;
                n_phase = PH_COLLECT;
                n_line  = '0;
            end
            if (n_phase == PH_COLLECT) begin
                if (i_byte == CH_CR) begin
                    n_held = 1'b1;
                end else if (i_byte == CH_LF) begin
                    o_push = 1'b1;
                    o_job.status = ST_STORED;
                    if (!n_line.nonblank) begin
                        o_job.status = ST_END;
                        n_phase = PH_ENDED;
                    end else if (!n_line.colon) begin
                        o_job.status = ST_SKIP;
                        n_len  = '0;
                        n_held = 1'b0;
                        n_line = '0;
                    end else if (n_cnt >= CNT_W'(TABLE_MAX)) begin
                        o_job.status = ST_FULL;
                        n_phase = PH_FAILED;
                    end else if (nlen == '0 || {1'b0, nlen} >= 7'(NAME_MAX)) begin
                        o_job.status = ST_BADNM;
                        n_phase = PH_FAILED;
                    end else if ({1'b0, vlen} >= 7'(VALUE_MAX)) begin
                        o_job.status = ST_VLONG;
                        n_phase = PH_FAILED;
                    end else begin
                        o_job.emit   = 1'b1;
                        o_job.idx    = n_cnt[3:0];
                        o_job.nb     = n_line.nb;
                        o_job.ne     = n_line.ne;
                        o_job.vb     = n_line.vb;
                        o_job.ve     = n_line.ve;
                        o_job.vempty = !n_line.seen_v;
                        n_cnt  = n_cnt + 1'b1;
                        n_len  = '0;
                        n_held = 1'b0;
                        n_line = '0;
                    end
                end else if (n_held) begin
                    n_held  = 1'b0;
                    st_do   = 1'b1;
                    st_x    = CH_CR;
                    n_pend  = 1'b1;
                    n_pbyte = i_byte;
                end else begin
                    st_do = 1'b1;
                    st_x  = i_byte;
                end
            end
        end
        if (st_do) begin
            if (n_len >= POS_W'(LINE_MAX - 1)) begin
                o_push       = 1'b1;
                o_job        = '0;
                o_job.status = ST_LLONG;
                n_phase      = PH_FAILED;
                n_pend       = 1'b0;
            end else begin
                o_we    = 1'b1;
                o_waddr = n_len;
                o_wdata = st_x;
                if (!is_ws(st_x)) begin
                    n_line.nonblank = 1'b1;
                end
                if (!n_line.colon) begin
                    if (st_x == CH_COLON) begin
                        n_line.colon = 1'b1;
                    end else if (!is_ws(st_x)) begin
                        if (!n_line.seen_n) begin
                            n_line.nb = n_len;
                        end
                        n_line.seen_n = 1'b1;
                        n_line.ne     = n_len + 1'b1;
                    end
                end else if (!is_ws(st_x)) begin
                    if (!n_line.seen_v) begin
                        n_line.vb = n_len;
                    end
                    n_line.seen_v = 1'b1;
                    n_line.ve     = n_len + 1'b1;
                end
                n_len = n_len + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_held  <= 1'b0;
            r_cnt   <= '0;
            r_phase <= PH_COLLECT;
            r_pend  <= 1'b0;
            r_line  <= '0;
        end else begin
            r_len   <= n_len;
            r_held  <= n_held;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_line  <= n_line;
        end
        r_pbyte <= n_pbyte;
    end
endmodule

@@ hdl/hlt_fifo.sv @@
// Two-entry job queue between the front and back parts.
// Depends on hlt_pkg for the job type.
module hlt_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hlt_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output hlt_pkg::t_job o_job,
    input  logic          i_pop
);
    import hlt_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop && o_valid};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

@@ hdl/hlt_back.sv @@
// Back part: replays a stored line from the line store as name and value
// characters and a status item into the output register. Depends on hlt_pkg.
module hlt_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  hlt_pkg::t_job             i_q_job,
    output logic                      o_pop,
    input  logic                      i_push_emit,
    output logic                      o_char_busy,
    output logic                      o_re,
    output logic [hlt_pkg::POS_W-1:0] o_raddr,
    input  logic [7:0]                i_rdata,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_char,
    output logic [2:0]                o_status,
    output logic [3:0]                o_idx
);
    import hlt_pkg::*;

    t_job             r_job;
    logic             r_act;
    logic [1:0]       r_sel;
    logic [POS_W-1:0] r_ptr;
    logic [1:0]       r_cjobs;
    logic             r_rd_v;
    logic [1:0]       r_rd_kind;
    logic [2:0]       r_rd_st;
    logic [3:0]       r_rd_idx;
    logic             r_ov;
    logic [1:0]       r_okind;
    logic [7:0]       r_ochar;
    logic [2:0]       r_ost;
    logic [3:0]       r_oidx;

    logic       out_load, issue, done_emit;
    logic [7:0] ch;

    assign out_load    = r_rd_v && (!r_ov || i_ready);
    assign issue       = r_act && (!r_rd_v || out_load);
    assign o_pop       = !r_act && i_q_valid;
    assign o_re        = issue && r_sel != KIND_STATUS;
    assign o_raddr     = r_ptr;
    assign done_emit   = issue && r_sel == KIND_STATUS && r_job.emit;
    assign o_char_busy = r_cjobs != 2'd0;

    always_comb begin
        ch = 8'h00;
        if (r_rd_kind == KIND_NAME) begin
            ch = (i_rdata >= 8'h41 && i_rdata <= 8'h5A) ? i_rdata + 8'h20 : i_rdata;
        end else if (r_rd_kind == KIND_VALUE) begin
            ch = i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_cjobs <= 2'd0;
            r_rd_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_cjobs <= r_cjobs + {1'b0, i_push_emit} - {1'b0, done_emit};
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (issue && r_sel == KIND_STATUS) begin
                r_act <= 1'b0;
            end
            if (issue) begin
                r_rd_v <= 1'b1;
            end else if (out_load) begin
                r_rd_v <= 1'b0;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (o_pop) begin
            r_job <= i_q_job;
            r_sel <= i_q_job.emit ? KIND_NAME : KIND_STATUS;
            r_ptr <= i_q_job.nb;
        end else if (issue) begin
            case (r_sel)
                KIND_NAME: begin
                    if (r_ptr + 1'b1 == r_job.ne) begin
                        r_sel <= r_job.vempty ? KIND_STATUS : KIND_VALUE;
                        r_ptr <= r_job.vb;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                KIND_VALUE: begin
                    if (r_ptr + 1'b1 == r_job.ve) begin
                        r_sel <= KIND_STATUS;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                default: begin
                    r_sel <= KIND_STATUS;
                end
            endcase
        end
        if (issue) begin
            r_rd_kind <= r_sel;
            r_rd_st   <= (r_sel == KIND_STATUS) ? r_job.status : ST_STORED;
            r_rd_idx  <= (r_sel == KIND_STATUS) ? r_job.idx : 4'd0;
        end
        if (out_load) begin
            r_okind <= r_rd_kind;
            r_ochar <= ch;
            r_ost   <= r_rd_st;
            r_oidx  <= r_rd_idx;
        end
    end

    assign o_valid  = r_ov;
    assign o_kind   = r_okind;
    assign o_char   = r_ochar;
    assign o_status = r_ost;
    assign o_idx    = r_oidx;
endmodule

@@ hdl/header_line_tokenizer_core.sv @@
// Top level of the header line tokenizer: front, job queue, line store, back.
// Depends on hlt_pkg, hlt_front, hlt_fifo, hlt_ram and hlt_back.
//
// The slave channel takes one header byte per transfer in tdata, with tuser
// set to start a new block before that byte. The master channel gives one
// result per transfer: a lower-cased name character, a value character or
// a status item, which always carries tlast and closes the run of a line.
// A byte that follows a held CR stalls tready while the CR and the byte are
// written to the line store in turn, as it has a single write port. At LF the
// line is replayed from the store at one character per cycle while the
// receiver keeps up, and tready stays low until the last character has been
// read. Reset clears the block to the collecting phase with an empty table.
// When the receiver stalls, results wait in the read and output registers and
// jobs wait in the queue, and tready falls once the queue is full or a line is
// being replayed.
module header_line_tokenizer_core #(
    parameter int LINE_MAX  = hlt_pkg::LINE_MAX_DEF,
    parameter int NAME_MAX  = hlt_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = hlt_pkg::VALUE_MAX_DEF,
    parameter int TABLE_MAX = hlt_pkg::TABLE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic        i_s_tuser,   // start_block
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // out_char, status, entry_index, zero fill
    output logic [1:0]  o_m_tuser,   // kind
    output logic        o_m_tlast    // last
);
    import hlt_pkg::*;

    localparam int AW = $clog2(LINE_MAX);

    logic             push, q_full, q_valid, pop, char_busy;
    t_job             push_job, q_job;
    logic             we, re;
    logic [POS_W-1:0] waddr, raddr;
    logic [7:0]       wdata, rdata, ochar;
    logic [2:0]       ost;
    logic [3:0]       oidx;

    hlt_front #(
        .LINE_MAX(LINE_MAX), .NAME_MAX(NAME_MAX),
        .VALUE_MAX(VALUE_MAX), .TABLE_MAX(TABLE_MAX)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready),
        .i_byte(i_s_tdata), .i_start(i_s_tuser),
        .i_char_busy(char_busy), .i_q_full(q_full),
        .o_push(push), .o_job(push_job),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata)
    );

    hlt_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_job(push_job), .o_full(q_full),
        .o_valid(q_valid), .o_job(q_job), .i_pop(pop)
    );

    hlt_ram #(.W(8), .D(LINE_MAX)) u_ram (
        .i_clk(i_clk),
        .i_we(we), .i_waddr(waddr[AW-1:0]), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr[AW-1:0]), .o_rdata(rdata)
    );

    hlt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_job(q_job), .o_pop(pop),
        .i_push_emit(push && push_job.emit), .o_char_busy(char_busy),
        .o_re(re), .o_raddr(raddr), .i_rdata(rdata),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_kind(o_m_tuser), .o_char(ochar), .o_status(ost), .o_idx(oidx)
    );

    assign o_m_tdata = {1'b0, oidx, ost, ochar};
    assign o_m_tlast = o_m_tuser == KIND_STATUS;
endmodule

@@ hdl/hlt_checker.sv @@
// Port-level checker for the header line tokenizer, bound to the top level.
// Depends on hlt_pkg and header_line_tokenizer_core.
module hlt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import hlt_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("Result offered straight after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled result was dropped or changed.");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tlast == (o_m_tuser == KIND_STATUS))
        else $error("tlast does not mark the status item alone.");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != KIND_STATUS |-> o_m_tdata[15:8] == 8'h00)
        else $error("Character item carries a status or index.");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != 2'd3)
        else $error("Result has an undefined kind.");
endmodule

bind header_line_tokenizer_core hlt_checker u_hlt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
);

@@ bench/header_line_tokenizer_core_tb.sv @@
// Self-checking testbench for header_line_tokenizer_core: drives header bytes,
// predicts every name, value and status transfer and compares them in order.
// Depends on hlt_pkg and the header_line_tokenizer_core RTL.
`timescale 1ns / 1ps

module header_line_tokenizer_core_tb;
    import hlt_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
    } t_byte_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [2:0] status;
        logic [3:0] idx;
        logic       last;
    } t_token;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    t_byte_item pending_bytes[$];
    t_token     expected_tokens[$];

    logic [7:0] line_buf[64];
    int         fill_len;
    logic       cr_held;
    int         hdr_count;
    logic [1:0] tok_phase;

    int  errors;
    int  cycles;
    bit  calm;
    bit  hold_send;
    bit  s_taken;
    int  send_gap;
    int  recv_gap;

    header_line_tokenizer_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit blank_char(input logic [7:0] b);
        return b == CH_SP || b == CH_TAB || b == CH_FF || b == CH_VT || b == CH_CR;
    endfunction

    function automatic void push_token(input logic [1:0] k, input logic [7:0] c,
                                       input logic [2:0] s, input logic [3:0] ix,
                                       input logic l);
        t_token t;
        t.kind = k; t.ch = c; t.status = s; t.idx = ix; t.last = l;
        expected_tokens.push_back(t);
    endfunction

    function automatic void abort_block(input logic [2:0] s);
        tok_phase = PH_FAILED;
        push_token(KIND_STATUS, 8'h00, s, 4'd0, 1'b1);
    endfunction

    function automatic bit append_char(input logic [7:0] b);
        if (fill_len >= LINE_MAX_DEF - 1) begin
            abort_block(ST_LLONG);
            return 1'b1;
        end
        line_buf[fill_len] = b;
        fill_len++;
        return 1'b0;
    endfunction

    function automatic void close_line();
        int  colon, nb, ne, vb, ve;
        bit  blank;
        logic [7:0] c;
        blank = 1'b1;
        for (int i = 0; i < fill_len; i++)
            if (!blank_char(line_buf[i])) blank = 1'b0;
        if (blank) begin
            tok_phase = PH_ENDED;
            push_token(KIND_STATUS, 8'h00, ST_END, 4'd0, 1'b1);
            return;
        end
        colon = fill_len;
        for (int i = fill_len - 1; i >= 0; i--)
            if (line_buf[i] == CH_COLON) colon = i;
        if (colon == fill_len) begin
            fill_len = 0;
            cr_held = 1'b0;
            push_token(KIND_STATUS, 8'h00, ST_SKIP, 4'd0, 1'b1);
            return;
        end
        if (hdr_count >= TABLE_MAX_DEF) begin
            abort_block(ST_FULL);
            return;
        end
        nb = 0;
        while (nb < colon && blank_char(line_buf[nb])) nb++;
        ne = colon;
        while (ne > nb && blank_char(line_buf[ne-1])) ne--;
        if (ne == nb || ne - nb >= NAME_MAX_DEF) begin
            abort_block(ST_BADNM);
            return;
        end
        vb = colon + 1;
        while (vb < fill_len && blank_char(line_buf[vb])) vb++;
        ve = fill_len;
        while (ve > vb && blank_char(line_buf[ve-1])) ve--;
        if (ve - vb >= VALUE_MAX_DEF) begin
            abort_block(ST_VLONG);
            return;
        end
        for (int i = nb; i < ne; i++) begin
            c = line_buf[i];
            if (c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
            push_token(KIND_NAME, c, ST_STORED, 4'd0, 1'b0);
        end
        for (int i = vb; i < ve; i++)
            push_token(KIND_VALUE, line_buf[i], ST_STORED, 4'd0, 1'b0);
        push_token(KIND_STATUS, 8'h00, ST_STORED, hdr_count[3:0], 1'b1);
        hdr_count++;
        fill_len = 0;
        cr_held = 1'b0;
    endfunction

    function automatic void predict_tokens(input t_byte_item it);
        if (it.start) begin
            fill_len = 0;
            cr_held = 1'b0;
            hdr_count = 0;
            tok_phase = PH_COLLECT;
        end
        if (tok_phase != PH_COLLECT) return;
        if (it.ch == CH_CR) begin
            cr_held = 1'b1;
            return;
        end
        if (it.ch == CH_LF) begin
            close_line();
            return;
        end
        if (cr_held) begin
            cr_held = 1'b0;
            if (append_char(CH_CR)) return;
        end
        void'(append_char(it.ch));
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic s = 1'b0);
        t_byte_item it;
        it.ch = b;
        it.start = s;
        pending_bytes.push_back(it);
    endtask

    task automatic add_text(input string s, input logic first_start = 1'b0);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], (i == 0) ? first_start : 1'b0);
    endtask

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 9))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_COLON;
            4:       return 8'($urandom_range(8'h41, 8'h5A));
            5:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    task automatic add_random_line();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 10);
        if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(0, 2)) add_byte(CH_SP);
            repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(8'h41, 8'h7A)));
            add_byte(CH_COLON);
        end
        repeat (n) add_byte(random_char());
        if ($urandom_range(0, 1)) add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!i_s_tvalid || s_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (hold_send || pending_bytes.size() == 0) begin
                i_s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 17) - 1;
                i_s_tvalid <= 1'b0;
            end else begin
                i_s_tdata <= pending_bytes[0].ch;
                i_s_tuser <= pending_bytes[0].start;
                i_s_tvalid <= 1'b1;
                void'(pending_bytes.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_gap <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 17) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_token exp_tok;
        cycles <= cycles + 1;
        s_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            t_byte_item it;
            it.ch = i_s_tdata;
            it.start = i_s_tuser;
            predict_tokens(it);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected result transfer: tdata %h tuser %0d", o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                exp_tok = expected_tokens.pop_front();
                if (o_m_tuser !== exp_tok.kind) begin
                    $error("kind: expected %0d, got %0d", exp_tok.kind, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata[7:0] !== exp_tok.ch) begin
                    $error("out_char: expected %h, got %h", exp_tok.ch, o_m_tdata[7:0]);
                    errors++;
                end
                if (o_m_tdata[10:8] !== exp_tok.status) begin
                    $error("status: expected %0d, got %0d", exp_tok.status, o_m_tdata[10:8]);
                    errors++;
                end
                if (o_m_tdata[14:11] !== exp_tok.idx) begin
                    $error("entry_index: expected %0d, got %0d", exp_tok.idx,
                           o_m_tdata[14:11]);
                    errors++;
                end
                if (o_m_tlast !== exp_tok.last) begin
                    $error("last: expected %0d, got %0d", exp_tok.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        hold_send = 1'b0;
        fill_len = 0;
        cr_held = 1'b0;
        hdr_count = 0;
        tok_phase = PH_COLLECT;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 8'h00;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;

        add_text(" Host :\tEx\r\rA \r\n", 1'b1);
        add_text("nocolon\n");
        add_text(":v\n");
        add_byte(8'h00); add_byte(8'hFF); add_text(":\n");
        add_text("a:\r\n");
        add_text(" \t\n");
        add_text("ignored\n");
        add_byte(CH_CR, 1'b1);
        add_byte(CH_LF);
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        repeat (6) begin
            add_byte(8'h78, 1'b1);
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(0, 5) == 0) add_byte(random_char());
                add_random_line();
                if (pending_bytes.size() > 420 && i > 2) break;
            end
            if ($urandom_range(0, 1)) add_text("\r\n");
        end
        add_byte(8'h41, 1'b1);
        for (int i = 0; i < 17; i++) add_text("K:v\n");
        repeat (70) add_byte(8'h5A);

        wait (pending_bytes.size() < 200);
        hold_send = 1'b1;
        wait (expected_tokens.size() == 0 && !i_s_tvalid);
        repeat (10) @(posedge i_clk);
        hold_send = 1'b0;
        wait (pending_bytes.size() < 80);
        calm = 1'b1;
        wait (pending_bytes.size() == 0 && !i_s_tvalid);
        wait (expected_tokens.size() == 0);
        repeat (150) @(posedge i_clk);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/hlt_pkg.sv
hdl/hlt_ram.sv
hdl/hlt_front.sv
hdl/hlt_fifo.sv
hdl/hlt_back.sv
hdl/header_line_tokenizer_core.sv
hdl/hlt_checker.sv
bench/header_line_tokenizer_core_tb.sv
